### rtl/rbb_pkg.sv
`default_nettype none
package rbb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int CHAN_W   = 8;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int FW_W     = 11;
    localparam int FH_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = FH_W;
    localparam int SUM_W    = 12;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
    localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
    localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);

    // Reciprocal of ten scaled by 2^15; exact floor for sums below 16384.
    localparam logic [SUM_W-1:0] RECIP10 = SUM_W'(3277);
    localparam int RECIP_SHIFT = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_idx_t;

    // Channel 2 is red, 1 is green, 0 is blue.
    typedef logic [2:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] addr;
        logic             wr_a_en;
        logic             wr_b_en;
        logic [COL_W-1:0] wr_b_addr;
    } ls_ctrl_t;

    function automatic logic [CHAN_W-1:0] div10(input logic [SUM_W-1:0] s);
        logic [2*SUM_W-1:0] p;
        p = {{SUM_W{1'b0}}, s} * {{SUM_W{1'b0}}, RECIP10};
        return p[RECIP_SHIFT +: CHAN_W];
    endfunction

endpackage
`default_nettype wire

### rtl/rbb_line_store.sv
`default_nettype none
module rbb_line_store (
    input  wire logic            clk,
    input  wire rbb_pkg::ls_ctrl_t ctrl,
    input  wire rbb_pkg::pixel_t wr_a_data,
    input  wire rbb_pkg::pixel_t wr_b_data,
    output rbb_pkg::pixel_t      mid,
    output rbb_pkg::pixel_t      top
);

    rbb_pkg::pixel_t store_a [rbb_pkg::MAX_WIDTH];
    rbb_pkg::pixel_t store_b [rbb_pkg::MAX_WIDTH];
    rbb_pkg::pixel_t mid_reg;
    rbb_pkg::pixel_t top_reg;

    // Row above the incoming pixel. The read returns the old entry when
    // the same address is written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_a_en)
        begin
            store_a[ctrl.addr] <= wr_a_data;
        end
        if (ctrl.rd_en)
        begin
            mid_reg <= store_a[ctrl.addr];
        end
    end

    // Row two above; filled one stage later with the value read from store_a.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_b_en)
        begin
            store_b[ctrl.wr_b_addr] <= wr_b_data;
        end
        if (ctrl.rd_en)
        begin
            top_reg <= store_b[ctrl.addr];
        end
    end

    assign mid = mid_reg;
    assign top = top_reg;

endmodule
`default_nettype wire

### rtl/rgb_box_blur_3x3.sv
// Path: after the input transfer that completes its window, a result is registered at the
// line store read, then at the window sum, then at the divide by ten.
// Throughput: one pixel per cycle when not stalled; each step has its own register stage.
// Reset: counters, window and valid bits clear; frame size returns to 640 x 480.
// Line store contents are not cleared; every entry that feeds a result was written earlier in the frame.
`default_nettype none
module rgb_box_blur_3x3 (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [rbb_pkg::CHAN_W-1:0]      red_in,
    input  wire logic [rbb_pkg::CHAN_W-1:0]      green_in,
    input  wire logic [rbb_pkg::CHAN_W-1:0]      blue_in,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [rbb_pkg::CHAN_W-1:0]           red_out,
    output logic [rbb_pkg::CHAN_W-1:0]           green_out,
    output logic [rbb_pkg::CHAN_W-1:0]           blue_out,
    output logic [rbb_pkg::ROW_W-1:0]            center_row,
    output logic [rbb_pkg::COL_W-1:0]            center_col,
    output logic                                 frame_done,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rbb_pkg::CFG_W-1:0]       cfg_data
);

    localparam int COL_W = rbb_pkg::COL_W;
    localparam int ROW_W = rbb_pkg::ROW_W;
    localparam int SUM_W = rbb_pkg::SUM_W;
    localparam int CHAN_W = rbb_pkg::CHAN_W;

    // Configuration.
    logic [rbb_pkg::FW_W-1:0] fw_reg;
    logic [rbb_pkg::FH_W-1:0] fh_reg;
    logic [rbb_pkg::FW_W-1:0] w_clamp;
    logic [rbb_pkg::FH_W-1:0] h_clamp;
    logic [COL_W-1:0]         w_last;
    logic [ROW_W-1:0]         h_last;
    logic                     cfg_wr;
    logic                     cfg_hit;

    // Position of the next incoming pixel.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Pipeline control.
    logic accept;
    logic en1, en2, en_out;

    // Stage 1: pixel waiting for its line store read.
    logic             s1_valid_reg;
    rbb_pkg::pixel_t  s1_pix_reg;
    logic             s1_emit_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_crow_reg;
    logic [COL_W-1:0] s1_ccol_reg;
    logic             s1_done_reg;

    // Stage 2: channel sums.
    logic                  s2_valid_reg;
    logic [2:0][SUM_W-1:0] s2_sum_reg;
    logic [ROW_W-1:0]      s2_crow_reg;
    logic [COL_W-1:0]      s2_ccol_reg;
    logic                  s2_done_reg;

    // Output register.
    logic              out_valid_reg;
    logic [CHAN_W-1:0] red_out_reg, green_out_reg, blue_out_reg;
    logic [ROW_W-1:0]  crow_out_reg;
    logic [COL_W-1:0]  ccol_out_reg;
    logic              done_out_reg;

    rbb_pkg::pixel_t       win_reg [6];
    rbb_pkg::pixel_t       col_px  [3];
    rbb_pkg::pixel_t       mid_px, top_px, in_px;
    logic [2:0][SUM_W-1:0] sum_next;
    rbb_pkg::ls_ctrl_t     ls_ctrl;

    // Size clamping.
    always_comb
    begin
        priority if (fw_reg < rbb_pkg::FW_MIN)
            w_clamp = rbb_pkg::FW_MIN;
        else if (fw_reg > rbb_pkg::FW_MAX)
            w_clamp = rbb_pkg::FW_MAX;
        else
            w_clamp = fw_reg;

        priority if (fh_reg < rbb_pkg::FH_MIN)
            h_clamp = rbb_pkg::FH_MIN;
        else if (fh_reg > rbb_pkg::FH_MAX)
            h_clamp = rbb_pkg::FH_MAX;
        else
            h_clamp = fh_reg;
    end

    assign w_last = COL_W'(w_clamp - rbb_pkg::FW_W'(1));
    assign h_last = ROW_W'(h_clamp - rbb_pkg::FH_W'(1));

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && ((cfg_index == rbb_pkg::CFG_FRAME_WIDTH)
                               || (cfg_index == rbb_pkg::CFG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= rbb_pkg::FW_RESET;
            fh_reg <= rbb_pkg::FH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                rbb_pkg::CFG_FRAME_WIDTH:  fw_reg <= cfg_data[rbb_pkg::FW_W-1:0];
                rbb_pkg::CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Each stage moves forward when the one after it has room.
    assign en_out   = !out_valid_reg || !out_stall;
    assign en2      = !s2_valid_reg || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;

    assign in_px = {red_in, green_in, blue_in};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        ls_ctrl.rd_en     = en1;
        ls_ctrl.addr      = col_reg;
        ls_ctrl.wr_a_en   = accept;
        ls_ctrl.wr_b_en   = s1_valid_reg && en2;
        ls_ctrl.wr_b_addr = s1_col_reg;
    end

    rbb_line_store u_line_store (
        .clk       (clk),
        .ctrl      (ls_ctrl),
        .wr_a_data (in_px),
        .wr_b_data (mid_px),
        .mid       (mid_px),
        .top       (top_px)
    );

    // Stage 1 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= in_px;
            s1_col_reg  <= col_reg;
            s1_emit_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            s1_crow_reg <= row_reg - ROW_W'(1);
            s1_ccol_reg <= col_reg - COL_W'(1);
            s1_done_reg <= (row_reg == h_last) && (col_reg == w_last);
        end
    end

    // Window sums over the two stored columns and the new column.
    always_comb
    begin
        col_px[0] = top_px;
        col_px[1] = mid_px;
        col_px[2] = s1_pix_reg;
        for (int k = 0; k < 3; k++)
        begin
            sum_next[k] = '0;
            for (int q = 0; q < 3; q++)
            begin
                sum_next[k] = sum_next[k] + SUM_W'(win_reg[2*q][k])
                                          + SUM_W'(win_reg[2*q+1][k])
                                          + SUM_W'(col_px[q][k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_valid_reg && en2)
        begin
            for (int q = 0; q < 3; q++)
            begin
                win_reg[2*q]   <= win_reg[2*q+1];
                win_reg[2*q+1] <= col_px[q];
            end
        end
    end

    // Stage 2 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg && s1_emit_reg)
        begin
            s2_sum_reg  <= sum_next;
            s2_crow_reg <= s1_crow_reg;
            s2_ccol_reg <= s1_ccol_reg;
            s2_done_reg <= s1_done_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s2_valid_reg)
        begin
            red_out_reg   <= rbb_pkg::div10(s2_sum_reg[2]);
            green_out_reg <= rbb_pkg::div10(s2_sum_reg[1]);
            blue_out_reg  <= rbb_pkg::div10(s2_sum_reg[0]);
            crow_out_reg  <= s2_crow_reg;
            ccol_out_reg  <= s2_ccol_reg;
            done_out_reg  <= s2_done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = red_out_reg;
    assign green_out  = green_out_reg;
    assign blue_out   = blue_out_reg;
    assign center_row = crow_out_reg;
    assign center_col = ccol_out_reg;
    assign frame_done = done_out_reg;

endmodule
`default_nettype wire

### rtl/rbb_checker.sv
`default_nettype none
module rbb_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [rbb_pkg::CHAN_W-1:0] red_out,
    input wire logic [rbb_pkg::CHAN_W-1:0] green_out,
    input wire logic [rbb_pkg::CHAN_W-1:0] blue_out,
    input wire logic [rbb_pkg::ROW_W-1:0]  center_row,
    input wire logic [rbb_pkg::COL_W-1:0]  center_col,
    input wire logic                       frame_done
);

    // No result can be pending right after reset is released.
    a_no_result_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present at reset release");

    // Nine bytes over ten never exceed 229.
    a_blur_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_out <= 8'd229) && (green_out <= 8'd229)
                      && (blue_out <= 8'd229))
        else $error("blurred channel out of range");

    // Results are never tagged with row 0 or column 0, which are border positions.
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (center_row != '0) && (center_col != '0))
        else $error("result tagged with a border position");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out) && $stable(center_row)
            && $stable(center_col) && $stable(frame_done))
        else $error("stalled result changed");

endmodule

bind rgb_box_blur_3x3 rbb_checker u_rbb_checker (.*);
`default_nettype wire
